// ===== hdl/backslash_escape_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// Backslash escape decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and gated by rst_n.
// ----------------------------------------------------------------------------
`ifndef BACKSLASH_ESCAPE_DECODER_MACROS_SVH
`define BACKSLASH_ESCAPE_DECODER_MACROS_SVH

// Same-cycle implication.
`define BED_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BED_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bed_pkg.sv =====
// ----------------------------------------------------------------------------
// Backslash escape decoder package
// Request types, decode phases, queue command and default sizes.
// ----------------------------------------------------------------------------
package bed_pkg;

  localparam int OCTAL_DIGITS_DEF = 3;
  localparam int HEX_DIGITS_DEF   = 2;
  // power of two, at least 2
  localparam int QUEUE_DEPTH_DEF  = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_argument;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       stop;
    logic       last;
  } out_req_t;

  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_ESC   = 2'd1,
    PH_OCT   = 2'd2,
    PH_HEX   = 2'd3
  } phase_t;

  // up to two bytes produced by one input request
  typedef struct packed {
    logic [1:0] count;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       stop;
  } cmd_t;

endpackage

// ===== hdl/bed_front.sv =====
// ----------------------------------------------------------------------------
// Backslash escape decoder front end
// Accepts input requests, tracks the escape phase and emits commands.
// ----------------------------------------------------------------------------
module bed_front #(
  parameter int OCTAL_DIGITS = bed_pkg::OCTAL_DIGITS_DEF,
  parameter int HEX_DIGITS   = bed_pkg::HEX_DIGITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  bed_pkg::in_req_t in_req,
  input  logic             q_full,
  output logic             push,
  output bed_pkg::cmd_t    push_cmd
);

  `include "backslash_escape_decoder_macros.svh"

  localparam logic [1:0] OCT_LIM = 2'(OCTAL_DIGITS);
  localparam logic [1:0] HEX_LIM = 2'(HEX_DIGITS);
  localparam logic [7:0] BSL     = 8'h5C;

  function automatic logic [8:0] letter_code(input logic [7:0] b);
    logic [8:0] r;
    begin
      case (b)
        8'h5C:   r = {1'b1, 8'h5C};
        "a":     r = {1'b1, 8'd7};
        "b":     r = {1'b1, 8'd8};
        "e":     r = {1'b1, 8'd27};
        "f":     r = {1'b1, 8'd12};
        "n":     r = {1'b1, 8'd10};
        "r":     r = {1'b1, 8'd13};
        "t":     r = {1'b1, 8'd9};
        "v":     r = {1'b1, 8'd11};
        default: r = 9'd0;
      endcase
      return r;
    end
  endfunction

  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    begin
      if (b >= "0" && b <= "9")      r = {1'b1, b[3:0]};
      else if (b >= "a" && b <= "f") r = {1'b1, 4'(b - 8'h57)};
      else if (b >= "A" && b <= "F") r = {1'b1, 4'(b - 8'h37)};
      else                           r = 5'd0;
      return r;
    end
  endfunction

  bed_pkg::phase_t phase_r, phase_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [7:0]      val_r, val_nxt;
  logic            stopped_r, stopped_nxt;
  logic            esc_en_r;

  logic [7:0] b;
  logic       e;
  logic       accept;
  logic       is_hex;
  logic       dig_ok;
  logic [3:0] dig;
  logic [4:0] hx;
  logic [7:0] val_new;
  logic [1:0] cnt_new;
  logic       num_done;
  logic       esc_start;
  logic [8:0] lc;
  logic       oct_lead;
  logic       oct_lead_done;
  logic       fin;

  assign b        = in_req.in_byte;
  assign e        = in_req.end_of_argument;
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign is_hex    = (phase_r == bed_pkg::PH_HEX);
  assign hx        = hex_digit(b);
  assign dig_ok    = is_hex ? hx[4] : (b[7:3] == 5'b00110);
  assign dig       = is_hex ? hx[3:0] : {1'b0, b[2:0]};
  assign val_new   = is_hex ? {val_r[3:0], dig} : {val_r[4:0], dig[2:0]};
  assign cnt_new   = cnt_r + 2'd1;
  assign num_done  = (cnt_new >= (is_hex ? HEX_LIM : OCT_LIM)) || e;
  assign fin       = (val_r != 8'd0);
  assign esc_start = (b == BSL) && !e;
  assign lc        = letter_code(b);
  assign oct_lead  = (b[7:3] == 5'b00110) && (b[2:0] != 3'd0);
  assign oct_lead_done = (OCT_LIM <= 2'd1) || e;

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    cnt_nxt     = cnt_r;
    val_nxt     = val_r;
    stopped_nxt = stopped_r;
    if (!stopped_r) begin
      if (!esc_en_r) begin
        phase_nxt = bed_pkg::PH_PLAIN;
        cnt_nxt   = 2'd0;
        val_nxt   = 8'd0;
      end else begin
        case (phase_r)
          bed_pkg::PH_PLAIN: begin
            if (esc_start) phase_nxt = bed_pkg::PH_ESC;
          end
          bed_pkg::PH_ESC: begin
            phase_nxt = bed_pkg::PH_PLAIN;
            cnt_nxt   = 2'd0;
            val_nxt   = 8'd0;
            if (b == "c") begin
              stopped_nxt = 1'b1;
            end else if ((b == "0" || b == "x") && !e) begin
              phase_nxt = (b == "x") ? bed_pkg::PH_HEX : bed_pkg::PH_OCT;
            end else if (oct_lead && !oct_lead_done) begin
              phase_nxt = bed_pkg::PH_OCT;
              cnt_nxt   = 2'd1;
              val_nxt   = {5'd0, b[2:0]};
            end
          end
          bed_pkg::PH_OCT, bed_pkg::PH_HEX: begin
            if (dig_ok && !num_done) begin
              cnt_nxt = cnt_new;
              val_nxt = val_new;
            end else begin
              cnt_nxt   = 2'd0;
              val_nxt   = 8'd0;
              phase_nxt = (!dig_ok && esc_start) ? bed_pkg::PH_ESC : bed_pkg::PH_PLAIN;
            end
          end
          default: phase_nxt = bed_pkg::PH_PLAIN;
        endcase
      end
    end
  end

  // command output
  always_comb begin
    push_cmd = '0;
    if (!stopped_r) begin
      if (!esc_en_r) begin
        push_cmd.count = 2'd1;
        push_cmd.byte0 = b;
      end else begin
        case (phase_r)
          bed_pkg::PH_PLAIN: begin
            if (!esc_start) begin
              push_cmd.count = 2'd1;
              push_cmd.byte0 = b;
            end
          end
          bed_pkg::PH_ESC: begin
            if (lc[8]) begin
              push_cmd.count = 2'd1;
              push_cmd.byte0 = lc[7:0];
            end else if (b == "c") begin
              push_cmd.count = 2'd1;
              push_cmd.stop  = 1'b1;
            end else if (b == "0" || b == "x") begin
              push_cmd.count = 2'd0;
            end else if (b == "8" || b == "9") begin
              push_cmd.count = 2'd1;
              push_cmd.byte0 = b;
            end else if (oct_lead) begin
              if (oct_lead_done) begin
                push_cmd.count = 2'd1;
                push_cmd.byte0 = {5'd0, b[2:0]};
              end
            end else begin
              push_cmd.count = 2'd2;
              push_cmd.byte0 = BSL;
              push_cmd.byte1 = b;
            end
          end
          bed_pkg::PH_OCT, bed_pkg::PH_HEX: begin
            if (dig_ok) begin
              if (num_done && val_new != 8'd0) begin
                push_cmd.count = 2'd1;
                push_cmd.byte0 = val_new;
              end
            end else if (esc_start) begin
              push_cmd.count = fin ? 2'd1 : 2'd0;
              push_cmd.byte0 = val_r;
            end else if (fin) begin
              push_cmd.count = 2'd2;
              push_cmd.byte0 = val_r;
              push_cmd.byte1 = b;
            end else begin
              push_cmd.count = 2'd1;
              push_cmd.byte0 = b;
            end
          end
          default: push_cmd = '0;
        endcase
      end
    end
  end

  assign push = accept && (push_cmd.count != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= bed_pkg::PH_PLAIN;
      cnt_r     <= 2'd0;
      val_r     <= 8'd0;
      stopped_r <= 1'b0;
      esc_en_r  <= 1'b0;
    end else begin
      if (cfg_we) esc_en_r <= cfg_wdata;
      if (accept) begin
        phase_r   <= phase_nxt;
        cnt_r     <= cnt_nxt;
        val_r     <= val_nxt;
        stopped_r <= stopped_nxt;
      end
    end
  end

  `BED_ASSERT_NXT(a_stop_sticky, stopped_r, stopped_r, "stop flag cleared without reset")
  `BED_ASSERT_IMP(a_no_push_stopped, stopped_r, !push, "request pushed after stop")

endmodule

// ===== hdl/bed_queue.sv =====
// ----------------------------------------------------------------------------
// Backslash escape decoder command queue
// Small FIFO between the front end and the output stage.
// ----------------------------------------------------------------------------
module bed_queue #(
  parameter int DEPTH = bed_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bed_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output bed_pkg::cmd_t head
);

  `include "backslash_escape_decoder_macros.svh"

  localparam int AW = $clog2(DEPTH);

  bed_pkg::cmd_t   ent_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  `BED_ASSERT_IMP(a_no_overflow, push, !full, "push into full queue")
  `BED_ASSERT_IMP(a_no_underflow, pop, !empty, "pop from empty queue")

endmodule

// ===== hdl/bed_back.sv =====
// ----------------------------------------------------------------------------
// Backslash escape decoder output stage
// Unpacks queued commands into single result requests via an output register.
// ----------------------------------------------------------------------------
module bed_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  bed_pkg::cmd_t     head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output bed_pkg::out_req_t out_req
);

  `include "backslash_escape_decoder_macros.svh"

  logic              out_valid_r, out_valid_nxt;
  bed_pkg::out_req_t out_req_r, out_req_nxt;
  logic              sel_r, sel_nxt;
  logic              load;
  logic              is_last;

  assign load    = !out_valid_r || !out_stall;
  assign is_last = sel_r || (head.count == 2'd1);
  assign pop     = load && !q_empty && is_last;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_req_nxt   = out_req_r;
    sel_nxt       = sel_r;
    if (load) begin
      out_valid_nxt = !q_empty;
      if (!q_empty) begin
        out_req_nxt.out_byte = sel_r ? head.byte1 : head.byte0;
        out_req_nxt.stop     = head.stop && !sel_r;
        out_req_nxt.last     = is_last;
        sel_nxt              = !is_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_req_r <= out_req_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

  `BED_ASSERT_IMP(a_stop_last, out_valid_r && out_req_r.stop, out_req_r.last,
    "stop request not marked last")

endmodule

// ===== hdl/backslash_escape_decoder.sv =====
// Path: accepted inputs enter the 4-entry queue; results leave via the output
//   register. Throughput: 1 input per cycle while the queue is not full; two
//   results of one input leave one per cycle while out_stall is low.
// Reset: rst_n synchronous, active low; clears phase, stop flag, escape enable,
//   queue and output valid.
// ----------------------------------------------------------------------------
// Backslash escape decoder
// Echo-style escape decoding: front end decodes, queue decouples, back emits.
// ----------------------------------------------------------------------------
module backslash_escape_decoder #(
  parameter int OCTAL_DIGITS = bed_pkg::OCTAL_DIGITS_DEF,
  parameter int HEX_DIGITS   = bed_pkg::HEX_DIGITS_DEF,
  parameter int QUEUE_DEPTH  = bed_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  bed_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output bed_pkg::out_req_t out_req
);

  logic          q_full;
  logic          q_empty;
  logic          push;
  logic          pop;
  bed_pkg::cmd_t push_cmd;
  bed_pkg::cmd_t head;

  bed_front #(
    .OCTAL_DIGITS(OCTAL_DIGITS),
    .HEX_DIGITS  (HEX_DIGITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  bed_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (pop),
    .empty   (q_empty),
    .head    (head)
  );

  bed_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_req  (out_req)
  );

endmodule

// ===== tb/sv/backslash_escape_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Backslash escape decoder testbench
// Drives argument bytes through a queue-fed driver and checks every result
// request against a cycle-free predictor of the escape decoding. It covers
// both escape settings, directed corner cases, random escape sequences,
// back-pressure and a final backslash-c stop.
// ----------------------------------------------------------------------------
module backslash_escape_decoder_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PAD    = 8;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 250;
  localparam int OCT_DIGITS  = bed_pkg::OCTAL_DIGITS_DEF;
  localparam int HX_DIGITS   = bed_pkg::HEX_DIGITS_DEF;

  localparam logic [7:0] BSL   = 8'h5C;
  localparam logic [7:0] C_BEL = 8'd7;
  localparam logic [7:0] C_BS  = 8'd8;
  localparam logic [7:0] C_HT  = 8'd9;
  localparam logic [7:0] C_LF  = 8'd10;
  localparam logic [7:0] C_VT  = 8'd11;
  localparam logic [7:0] C_FF  = 8'd12;
  localparam logic [7:0] C_CR  = 8'd13;
  localparam logic [7:0] C_ESC = 8'd27;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  logic              cfg_wdata = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  bed_pkg::in_req_t  in_req    = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  bed_pkg::out_req_t out_req;

  backslash_escape_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  bed_pkg::phase_t dec_phase   = bed_pkg::PH_PLAIN;
  logic [1:0]      dec_count   = '0;
  logic [7:0]      dec_acc     = '0;
  bit              dec_stopped = 1'b0;
  bit              esc_on      = 1'b0;

  bed_pkg::in_req_t  arg_bytes_q[$];
  bed_pkg::out_req_t step_bytes[$];
  bed_pkg::out_req_t decoded_q[$];

  bit         tx_calm     = 1'b0;
  bit         rx_calm     = 1'b0;
  bit         allow_stop  = 1'b0;
  logic       hold_kick   = 1'b0;
  int         hold_left   = 0;
  logic [7:0] last_queued = '0;

  int cycles     = 0;
  int errors     = 0;
  int n_queued   = 0;
  int n_accepted = 0;
  int n_results  = 0;
  int n_cfg      = 0;

  function void emit(input logic [7:0] b, input logic s);
    bed_pkg::out_req_t r;
    r.out_byte = b;
    r.stop     = s;
    r.last     = 1'b0;
    step_bytes.push_back(r);
  endfunction

  function void clear_number();
    dec_phase = bed_pkg::PH_PLAIN;
    dec_count = '0;
    dec_acc   = '0;
  endfunction

  function void flush_number();
    logic [7:0] v;
    v = dec_acc;
    clear_number();
    if (v != 8'd0) emit(v, 1'b0);
  endfunction

  function void plain_in(input logic [7:0] b, input logic eoa);
    if (b == BSL && !eoa) dec_phase = bed_pkg::PH_ESC;
    else emit(b, 1'b0);
  endfunction

  function void escape_in(input logic [7:0] b, input logic eoa);
    dec_phase = bed_pkg::PH_PLAIN;
    case (b)
      BSL: emit(BSL, 1'b0);
      "a": emit(C_BEL, 1'b0);
      "b": emit(C_BS, 1'b0);
      "e": emit(C_ESC, 1'b0);
      "f": emit(C_FF, 1'b0);
      "n": emit(C_LF, 1'b0);
      "r": emit(C_CR, 1'b0);
      "t": emit(C_HT, 1'b0);
      "v": emit(C_VT, 1'b0);
      "c": begin
        dec_stopped = 1'b1;
        emit(8'd0, 1'b1);
      end
      "0", "x": begin
        dec_phase = (b == "x") ? bed_pkg::PH_HEX : bed_pkg::PH_OCT;
        dec_count = '0;
        dec_acc   = '0;
        if (eoa) flush_number();
      end
      "8", "9": emit(b, 1'b0);
      default: begin
        if (b >= "1" && b <= "7") begin
          dec_phase = bed_pkg::PH_OCT;
          dec_count = 2'd1;
          dec_acc   = b - "0";
          if (OCT_DIGITS <= 1 || eoa) flush_number();
        end else begin
          emit(BSL, 1'b0);
          emit(b, 1'b0);
        end
      end
    endcase
  endfunction

  function void number_in(input logic [7:0] b, input logic eoa, input bit hex);
    int d;
    int lim;
    int tmp;
    lim = hex ? HX_DIGITS : OCT_DIGITS;
    if (b >= "0" && b <= "7") d = int'(b - "0");
    else if (hex && b >= "8" && b <= "9") d = int'(b - "0");
    else if (hex && b >= "a" && b <= "f") d = int'(b - "a") + 10;
    else if (hex && b >= "A" && b <= "F") d = int'(b - "A") + 10;
    else d = -1;
    if (d >= 0) begin
      tmp       = int'(dec_acc) * (hex ? 16 : 8) + d;
      dec_acc   = tmp[7:0];
      dec_count = dec_count + 2'd1;
      if (int'(dec_count) >= lim || eoa) flush_number();
    end else begin
      flush_number();
      plain_in(b, eoa);
    end
  endfunction

  function void decode_request(input bed_pkg::in_req_t r);
    bed_pkg::out_req_t o;
    step_bytes.delete();
    if (!dec_stopped) begin
      if (!esc_on) begin
        clear_number();
        emit(r.in_byte, 1'b0);
      end else begin
        case (dec_phase)
          bed_pkg::PH_ESC: escape_in(r.in_byte, r.end_of_argument);
          bed_pkg::PH_OCT: number_in(r.in_byte, r.end_of_argument, 1'b0);
          bed_pkg::PH_HEX: number_in(r.in_byte, r.end_of_argument, 1'b1);
          default:         plain_in(r.in_byte, r.end_of_argument);
        endcase
      end
    end
    for (int i = 0; i < step_bytes.size(); i++) begin
      o      = step_bytes[i];
      o.last = (i == step_bytes.size() - 1);
      decoded_q.push_back(o);
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_request(in_req);
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (arg_bytes_q.size() != 0 && (tx_calm || $urandom_range(0, 99) >= 20)) begin
          in_valid <= 1'b1;
          in_req   <= arg_bytes_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_kick) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    bed_pkg::out_req_t exp_r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (decoded_q.size() == 0) begin
          if (errors < 10)
            $display("unexpected result: byte %02h stop %0b last %0b",
                     out_req.out_byte, out_req.stop, out_req.last);
          errors++;
        end else begin
          exp_r = decoded_q.pop_front();
          if (out_req.stop !== exp_r.stop || out_req.last !== exp_r.last ||
              (!exp_r.stop && out_req.out_byte !== exp_r.out_byte)) begin
            if (errors < 10)
              $display({"mismatch: expected byte %02h stop %0b last %0b, ",
                        "got byte %02h stop %0b last %0b"},
                       exp_r.out_byte, exp_r.stop, exp_r.last,
                       out_req.out_byte, out_req.stop, out_req.last);
            errors++;
          end
        end
      end
      out_stall <= (hold_left != 0) || (!rx_calm && $urandom_range(0, 99) < 20);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // a random backslash-c would stop the block for good; keep it for the end
  task automatic queue_byte(input logic [7:0] b, input logic eoa);
    bed_pkg::in_req_t r;
    if (last_queued == BSL && b == "c" && !allow_stop) b = "d";
    r.in_byte         = b;
    r.end_of_argument = eoa;
    arg_bytes_q.push_back(r);
    last_queued = b;
    n_queued++;
  endtask

  task automatic queue_token();
    int         kind;
    int         n;
    int         k;
    logic [7:0] b;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: begin
        b = 8'($urandom_range(8'h20, 8'h7E));
        queue_byte(b, $urandom_range(0, 9) == 0);
      end
      2: begin
        b = 8'($urandom_range(0, 255));
        queue_byte(b, $urandom_range(0, 9) == 0);
      end
      3: begin
        case ($urandom_range(0, 8))
          0: b = BSL;
          1: b = "a";
          2: b = "b";
          3: b = "e";
          4: b = "f";
          5: b = "n";
          6: b = "r";
          7: b = "t";
          default: b = "v";
        endcase
        queue_byte(BSL, $urandom_range(0, 9) == 0);
        queue_byte(b, $urandom_range(0, 9) == 0);
      end
      4, 5: begin
        queue_byte(BSL, $urandom_range(0, 9) == 0);
        if (kind == 4) begin
          queue_byte("0", $urandom_range(0, 9) == 0);
          n = $urandom_range(0, 4);
        end else begin
          b = 8'("0" + $urandom_range(1, 7));
          queue_byte(b, $urandom_range(0, 9) == 0);
          n = $urandom_range(0, 3);
        end
        for (int i = 0; i < n; i++) begin
          b = 8'("0" + $urandom_range(0, 7));
          queue_byte(b, $urandom_range(0, 9) == 0);
        end
      end
      6: begin
        queue_byte(BSL, $urandom_range(0, 9) == 0);
        queue_byte("x", $urandom_range(0, 9) == 0);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          k = $urandom_range(0, 21);
          if (k < 10) b = 8'("0" + k);
          else if (k < 16) b = 8'("a" + k - 10);
          else b = 8'("A" + k - 16);
          queue_byte(b, $urandom_range(0, 9) == 0);
        end
      end
      7: begin
        queue_byte(BSL, $urandom_range(0, 9) == 0);
        b = $urandom_range(0, 1) ? "9" : "8";
        queue_byte(b, $urandom_range(0, 9) == 0);
      end
      8: begin
        queue_byte(BSL, $urandom_range(0, 9) == 0);
        b = 8'($urandom_range(0, 255));
        queue_byte(b, $urandom_range(0, 9) == 0);
      end
      default: begin
        queue_byte(BSL, $urandom_range(0, 9) == 0);
        queue_byte(BSL, $urandom_range(0, 9) == 0);
      end
    endcase
  endtask

  task automatic wait_idle();
    while (arg_bytes_q.size() != 0 || in_valid || decoded_q.size() != 0)
      @(negedge clk);
    repeat (IDLE_PAD) @(negedge clk);
  endtask

  task automatic set_escapes(input bit v);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    esc_on = v;
    n_cfg++;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int start;
    int n_swallowed;
    bit paused;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset setting passes escapes through
    queue_byte(BSL, 1'b0);
    queue_byte("n", 1'b0);
    queue_byte(8'hFF, 1'b1);

    set_escapes(1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(BSL, 1'b0);
    queue_byte("n", 1'b0);
    queue_byte(BSL, 1'b0);
    queue_byte("q", 1'b0);
    queue_byte(BSL, 1'b0);
    queue_byte("9", 1'b0);
    queue_byte(BSL, 1'b0);
    queue_byte("3", 1'b0);
    queue_byte("7", 1'b0);
    queue_byte("7", 1'b0);
    queue_byte(BSL, 1'b0);
    queue_byte("4", 1'b0);
    queue_byte("0", 1'b0);
    queue_byte("0", 1'b0);
    queue_byte(BSL, 1'b0);
    queue_byte("x", 1'b0);
    queue_byte("g", 1'b0);
    queue_byte(BSL, 1'b1);
    queue_byte(BSL, 1'b0);
    queue_byte("0", 1'b1);
    queue_byte(BSL, 1'b0);
    queue_byte("x", 1'b0);
    queue_byte("4", 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      set_escapes(ph % 3 != 2);
      tx_calm = (ph == 3 || ph == 6);
      rx_calm = (ph == 3);
      if (ph == 6) begin
        @(posedge clk);
        hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;
        @(negedge clk);
      end
      start  = n_queued;
      paused = 1'b0;
      while (n_queued - start < PHASE_ITEMS) begin
        queue_token();
        // sender pauses mid-phase until all results are in
        if (ph == 4 && !paused && n_queued - start >= PHASE_ITEMS / 2) begin
          wait_idle();
          paused = 1'b1;
        end
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    // stop at the very end: everything after it is swallowed
    set_escapes(1'b1);
    for (int i = 0; i < 10; i++) queue_token();
    queue_byte("Z", 1'b1);
    allow_stop = 1'b1;
    queue_byte(BSL, 1'b0);
    queue_byte("c", 1'b0);
    allow_stop = 1'b0;
    n_swallowed = 20;
    for (int i = 0; i < n_swallowed; i++)
      queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

    wait_idle();
    repeat (20) @(negedge clk);

    $display("Covered %0d input requests (%0d after the stop) and %0d result requests,",
             n_accepted, n_swallowed, n_results);
    $display("over %0d escape setting writes with back-pressure; %0d mismatches.",
             n_cfg, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
